// File: design/bilinear_roi_crop_resize_macros.svh
// ----------------------------------------------------------------------------
// bilinear_roi_crop_resize_macros.svh
// Assertion shorthands shared by the crop/resize RTL. Expects clk and rst.
// ----------------------------------------------------------------------------
`ifndef BILINEAR_ROI_CROP_RESIZE_MACROS_SVH
`define BILINEAR_ROI_CROP_RESIZE_MACROS_SVH

// Condition must hold at every edge outside reset.
`define BRCR_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define BRCR_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

// File: design/brcr_pkg.sv
// ----------------------------------------------------------------------------
// brcr_pkg
// Types and fixed constants of the bilinear crop/resize block.
// ----------------------------------------------------------------------------
package brcr_pkg;

  // Widest frame index the job format carries (frame side up to 4096).
  localparam int IDX_W = 12;
  localparam int QUEUE_DEPTH = 4;

  // floor(x/10) = (x * SIDE_RECIP) >> SIDE_SHIFT, exact for x < 2^22
  localparam logic [19:0] SIDE_RECIP = 20'd838861;
  localparam int SIDE_SHIFT = 23;
  localparam int SIDE_W = 17;

  // floor(x/510) = (x * NORM_RECIP) >> NORM_SHIFT, exact for x < 2^25
  localparam logic [25:0] NORM_RECIP = 26'd33686019;
  localparam int NORM_SHIFT = 34;
  localparam logic [24:0] ROUND_BIAS = 25'd255;
  localparam logic signed [15:0] ZERO_POINT = 16'sd16384;

  typedef enum logic {
    KIND_STORE = 1'b0,
    KIND_CROP  = 1'b1
  } kind_e;

  typedef enum logic [2:0] {
    REG_SOURCE_WIDTH,
    REG_SOURCE_HEIGHT,
    REG_CROP_WIDTH,
    REG_CROP_HEIGHT,
    REG_BOX_CENTER_X,
    REG_BOX_CENTER_Y,
    REG_BOX_WIDTH,
    REG_BOX_HEIGHT
  } reg_index_e;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] src_col;
    logic [7:0] src_row;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
    logic [7:0] crop_col;
    logic [7:0] crop_row;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] red_out;
    logic signed [15:0] green_out;
    logic signed [15:0] blue_out;
    logic [7:0]         out_col;
    logic [7:0]         out_row;
  } out_item_t;

  typedef struct packed {
    logic [8:0]  source_width;
    logic [8:0]  source_height;
    logic [8:0]  crop_width;
    logic [8:0]  crop_height;
    logic [15:0] box_center_x;
    logic [15:0] box_center_y;
    logic [15:0] box_width;
    logic [15:0] box_height;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    source_width:  9'd256,
    source_height: 9'd256,
    crop_width:    9'd112,
    crop_height:   9'd112,
    box_center_x:  16'd32768,
    box_center_y:  16'd32768,
    box_width:     16'd16384,
    box_height:    16'd16384
  };

  // Classified work handed from the front to the back.
  typedef struct packed {
    kind_e            kind;
    logic             wr_ok;
    logic [IDX_W-1:0] x0;
    logic [IDX_W-1:0] x1;
    logic [IDX_W-1:0] y0;
    logic [IDX_W-1:0] y1;
    logic [7:0]       wx;
    logic [7:0]       wy;
    logic [23:0]      rgb;
    logic [7:0]       col;
    logic [7:0]       row;
  } job_t;

endpackage

// File: design/brcr_div.sv
// ----------------------------------------------------------------------------
// brcr_div
// Pipelined restoring divider, one quotient bit per stage, with a side tag.
// ----------------------------------------------------------------------------
module brcr_div #(
  parameter int NW = 26,
  parameter int DW = 10,
  parameter int TW = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_vld,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  input  logic [TW-1:0] tag_in,
  output logic          out_vld,
  output logic [NW-1:0] quo_out,
  output logic          rem_nz,
  output logic [TW-1:0] tag_out
);

  logic          vld  [NW];
  logic [DW-1:0] rem  [NW];
  logic [NW-1:0] nsh  [NW];
  logic [NW-1:0] quo  [NW];
  logic [TW-1:0] tag  [NW];
  logic [DW:0]   trial [NW];
  logic          ge   [NW];

  always_comb begin
    trial[0] = {DW'(0), num[NW-1]};
    ge[0]    = trial[0] >= {1'b0, den};
    for (int i = 1; i < NW; i++) begin
      trial[i] = {rem[i-1], nsh[i-1][NW-1]};
      ge[i]    = trial[i] >= {1'b0, den};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NW; i++) vld[i] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_vld;
      rem[0] <= ge[0] ? DW'(trial[0] - {1'b0, den}) : trial[0][DW-1:0];
      nsh[0] <= num << 1;
      quo[0] <= NW'(ge[0]);
      tag[0] <= tag_in;
      for (int i = 1; i < NW; i++) begin
        vld[i] <= vld[i-1];
        rem[i] <= ge[i] ? DW'(trial[i] - {1'b0, den}) : trial[i][DW-1:0];
        nsh[i] <= nsh[i-1] << 1;
        quo[i] <= {quo[i-1][NW-2:0], ge[i]};
        tag[i] <= tag[i-1];
      end
    end
  end

  assign out_vld = vld[NW-1];
  assign quo_out = quo[NW-1];
  assign rem_nz  = |rem[NW-1];
  assign tag_out = tag[NW-1];

endmodule

// File: design/brcr_front.sv
// ----------------------------------------------------------------------------
// brcr_front
// Accepts items, sorts stores from crop requests and maps requests to
// clamped source indices and Q8 weights.
// ----------------------------------------------------------------------------
`include "bilinear_roi_crop_resize_macros.svh"

module brcr_front #(
  parameter int SRC_MAX_WIDTH = 256,
  parameter int SRC_MAX_HEIGHT = 256,
  parameter int CROP_MAX_SIDE = 256
) (
  input  logic              clk,
  input  logic              rst,
  input  brcr_pkg::cfg_t    cfg,
  input  logic              start,
  input  brcr_pkg::in_item_t item,
  output logic              busy,
  input  logic              full,
  output logic              push,
  output brcr_pkg::job_t    job
);
  import brcr_pkg::*;

  localparam int CW   = $clog2(CROP_MAX_SIDE + 1);
  localparam int DW   = CW + 1;
  localparam int KW   = ((CW > 9) ? CW : 9) + 1;
  localparam int PW   = SIDE_W + 1 + KW;
  localparam int MAGW = SIDE_W + KW - 1;
  localparam int SW   = MAGW + 2;
  localparam int AW   = SW - 8;
  localparam int ITW  = $bits(in_item_t);

  logic adv;
  assign adv  = !full;
  assign busy = full;

  // effective sizes
  logic [CW-1:0]    crop_w_eff, crop_h_eff;
  logic [IDX_W-1:0] src_w_hi, src_h_hi;
  logic [DW-1:0]    den_x, den_y;

  always_comb begin
    crop_w_eff = (cfg.crop_width == '0) ? CW'(1) :
                 (int'(cfg.crop_width) > CROP_MAX_SIDE) ? CW'(CROP_MAX_SIDE) :
                 CW'(cfg.crop_width);
    crop_h_eff = (cfg.crop_height == '0) ? CW'(1) :
                 (int'(cfg.crop_height) > CROP_MAX_SIDE) ? CW'(CROP_MAX_SIDE) :
                 CW'(cfg.crop_height);
    src_w_hi = (cfg.source_width == '0) ? IDX_W'(0) :
               (int'(cfg.source_width) > SRC_MAX_WIDTH) ? IDX_W'(SRC_MAX_WIDTH - 1) :
               IDX_W'(int'(cfg.source_width) - 1);
    src_h_hi = (cfg.source_height == '0) ? IDX_W'(0) :
               (int'(cfg.source_height) > SRC_MAX_HEIGHT) ? IDX_W'(SRC_MAX_HEIGHT - 1) :
               IDX_W'(int'(cfg.source_height) - 1);
    den_x = DW'(2 * int'(crop_w_eff));
    den_y = DW'(2 * int'(crop_h_eff));
  end

  // stage 0: accept
  logic     f0_vld;
  in_item_t f0_item;

  // stage 1: box side times 11, crop offsets
  logic            f1_vld;
  in_item_t        f1_item;
  logic [19:0]     f1_sx;
  logic signed [KW-1:0] f1_kx, f1_ky;

  // stage 2: divide by ten
  logic            f2_vld;
  in_item_t        f2_item;
  logic [39:0]     f2_prod;
  logic signed [KW-1:0] f2_kx, f2_ky;

  // stage 3: numerators
  logic            f3_vld;
  in_item_t        f3_item;
  logic signed [PW-1:0] f3_numx, f3_numy;

  // stage 4: magnitudes into the dividers
  logic            f4_vld;
  logic [MAGW-1:0] f4_magx, f4_magy;
  logic            f4_negx, f4_negy;
  in_item_t        f4_item;

  logic [15:0]     box_max;
  logic [SIDE_W-1:0] side;
  logic signed [PW-1:0] abs_x, abs_y;

  always_comb begin
    box_max = (cfg.box_width > cfg.box_height) ? cfg.box_width : cfg.box_height;
    side    = f2_prod[SIDE_SHIFT +: SIDE_W];
    abs_x   = f3_numx[PW-1] ? -f3_numx : f3_numx;
    abs_y   = f3_numy[PW-1] ? -f3_numy : f3_numy;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f0_vld <= 1'b0;
      f1_vld <= 1'b0;
      f2_vld <= 1'b0;
      f3_vld <= 1'b0;
      f4_vld <= 1'b0;
    end else if (adv) begin
      f0_vld <= start;
      f1_vld <= f0_vld;
      f2_vld <= f1_vld;
      f3_vld <= f2_vld;
      f4_vld <= f3_vld;
    end
    if (adv) begin
      f0_item <= item;
      f1_item <= f0_item;
      f1_sx   <= 20'(box_max) * 20'd11 + 20'd5;
      f1_kx   <= KW'(2 * int'(f0_item.crop_col) + 1 - int'(crop_w_eff));
      f1_ky   <= KW'(2 * int'(f0_item.crop_row) + 1 - int'(crop_h_eff));
      f2_item <= f1_item;
      f2_prod <= 40'(f1_sx) * 40'(SIDE_RECIP);
      f2_kx   <= f1_kx;
      f2_ky   <= f1_ky;
      f3_item <= f2_item;
      f3_numx <= $signed({1'b0, side}) * f2_kx;
      f3_numy <= $signed({1'b0, side}) * f2_ky;
      f4_item <= f3_item;
      f4_negx <= f3_numx[PW-1];
      f4_negy <= f3_numy[PW-1];
      f4_magx <= abs_x[MAGW-1:0];
      f4_magy <= abs_y[MAGW-1:0];
    end
  end

  // per-axis dividers by twice the crop size
  logic            div_x_vld, div_y_vld, rnz_x, rnz_y;
  logic [MAGW-1:0] quo_x, quo_y;
  logic [ITW:0]    tag_x;
  logic            tag_y;

  brcr_div #(.NW(MAGW), .DW(DW), .TW(ITW + 1)) u_div_x (
    .clk(clk), .rst(rst), .en(adv), .in_vld(f4_vld),
    .num(f4_magx), .den(den_x), .tag_in({f4_negx, f4_item}),
    .out_vld(div_x_vld), .quo_out(quo_x), .rem_nz(rnz_x), .tag_out(tag_x)
  );

  brcr_div #(.NW(MAGW), .DW(DW), .TW(1)) u_div_y (
    .clk(clk), .rst(rst), .en(adv), .in_vld(f4_vld),
    .num(f4_magy), .den(den_y), .tag_in(f4_negy),
    .out_vld(div_y_vld), .quo_out(quo_y), .rem_nz(rnz_y), .tag_out(tag_y)
  );

  // floor the signed quotient and add the center
  logic signed [SW-1:0] qs_x, qs_y, qf_x, qf_y;
  in_item_t             dv_item;

  always_comb begin
    dv_item = in_item_t'(tag_x[ITW-1:0]);
    qs_x = SW'(quo_x);
    qs_y = SW'(quo_y);
    qf_x = tag_x[ITW] ? (~qs_x + SW'(!rnz_x)) : qs_x;
    qf_y = tag_y      ? (~qs_y + SW'(!rnz_y)) : qs_y;
  end

  logic                 g1_vld;
  in_item_t             g1_item;
  logic signed [SW-1:0] g1_sx, g1_sy;

  logic                 g2_vld;
  job_t                 g2_job;

  function automatic logic [IDX_W-1:0] clamp_idx(input logic signed [AW-1:0] a,
                                                 input logic [IDX_W-1:0] hi);
    logic [IDX_W-1:0] r;
    if (a < 0) r = '0;
    else if (a > $signed({1'b0, hi})) r = hi;
    else r = a[IDX_W-1:0];
    return r;
  endfunction

  logic signed [AW-1:0] ax, ay;
  job_t                 job_next;

  always_comb begin
    ax = g1_sx[SW-1:8];
    ay = g1_sy[SW-1:8];
    job_next.kind  = g1_item.kind;
    job_next.wr_ok = (int'(g1_item.src_col) < SRC_MAX_WIDTH) &&
                     (int'(g1_item.src_row) < SRC_MAX_HEIGHT);
    job_next.wx    = g1_sx[7:0];
    job_next.wy    = g1_sy[7:0];
    job_next.rgb   = {g1_item.red_in, g1_item.green_in, g1_item.blue_in};
    job_next.col   = g1_item.crop_col;
    job_next.row   = g1_item.crop_row;
    if (g1_item.kind == KIND_STORE) begin
      job_next.x0 = IDX_W'(g1_item.src_col);
      job_next.x1 = IDX_W'(g1_item.src_col);
      job_next.y0 = IDX_W'(g1_item.src_row);
      job_next.y1 = IDX_W'(g1_item.src_row);
    end else begin
      job_next.x0 = clamp_idx(ax, src_w_hi);
      job_next.x1 = clamp_idx(ax + AW'(1), src_w_hi);
      job_next.y0 = clamp_idx(ay, src_h_hi);
      job_next.y1 = clamp_idx(ay + AW'(1), src_h_hi);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      g1_vld <= 1'b0;
      g2_vld <= 1'b0;
    end else if (adv) begin
      g1_vld <= div_x_vld;
      g2_vld <= g1_vld;
    end
    if (adv) begin
      g1_item <= dv_item;
      g1_sx   <= SW'(cfg.box_center_x) + qf_x;
      g1_sy   <= SW'(cfg.box_center_y) + qf_y;
      g2_job  <= job_next;
    end
  end

  assign push = g2_vld && adv;
  assign job  = g2_job;

  `BRCR_ASSERT_ALWAYS(a_lanes_aligned, div_x_vld == div_y_vld, "divider lanes out of step")

endmodule

// File: design/brcr_queue.sv
// ----------------------------------------------------------------------------
// brcr_queue
// Short job queue between the front and the back.
// ----------------------------------------------------------------------------
`include "bilinear_roi_crop_resize_macros.svh"

module brcr_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  brcr_pkg::job_t job_in,
  output logic           full,
  input  logic           pop,
  output logic           empty,
  output brcr_pkg::job_t head
);
  import brcr_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  job_t             slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wptr, rptr;
  logic [CNT_W-1:0] count;

  assign full  = count == CNT_W'(QUEUE_DEPTH);
  assign empty = count == '0;
  assign head  = slots[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= (wptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr + 1'b1;
      if (pop)  rptr <= (rptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr + 1'b1;
      count <= count + CNT_W'(push) - CNT_W'(pop);
    end
    if (push) slots[wptr] <= job_in;
  end

  `BRCR_ASSERT_IMPL(a_pop_nonempty, pop, !empty, "pop from empty queue")
  `BRCR_ASSERT_ALWAYS(a_drains, count <= CNT_W'(1), "back fell behind the queue")

endmodule

// File: design/brcr_back.sv
// ----------------------------------------------------------------------------
// brcr_back
// Frame store in four parity banks, bilinear blend and [-1,1] mapping.
// ----------------------------------------------------------------------------
module brcr_back #(
  parameter int SRC_MAX_WIDTH = 256,
  parameter int SRC_MAX_HEIGHT = 256
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                empty,
  input  brcr_pkg::job_t      head,
  output logic                pop,
  output logic                done,
  output brcr_pkg::out_item_t result
);
  import brcr_pkg::*;

  // banks split by row and column parity: the four taps never collide
  localparam int HALF_W     = (SRC_MAX_WIDTH + 1) / 2;
  localparam int HALF_H     = (SRC_MAX_HEIGHT + 1) / 2;
  localparam int BANK_DEPTH = HALF_W * HALF_H;
  localparam int BAW        = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;

  assign pop = !empty;

  logic [BAW-1:0] raddr [4];
  logic           we    [4];
  logic [23:0]    rdata [4];

  always_comb begin
    for (int b = 0; b < 4; b++) begin
      logic [IDX_W-1:0] cs;
      logic [IDX_W-1:0] rs;
      cs = (head.x0[0] == b[0]) ? head.x0 : head.x1;
      rs = (head.y0[0] == b[1]) ? head.y0 : head.y1;
      raddr[b] = BAW'(int'(rs >> 1) * HALF_W + int'(cs >> 1));
      we[b] = pop && (head.kind == KIND_STORE) && head.wr_ok &&
              (head.x0[0] == b[0]) && (head.y0[0] == b[1]);
    end
  end

  for (genvar b = 0; b < 4; b++) begin : g_bank
    logic [23:0] mem [BANK_DEPTH];
    always_ff @(posedge clk) begin
      if (we[b]) mem[raddr[b]] <= head.rgb;
      if (pop) rdata[b] <= mem[raddr[b]];
    end
  end

  // S1: read issued, weights
  logic        s1_vld;
  logic        s1_x0p, s1_x1p, s1_y0p, s1_y1p;
  logic [16:0] s1_w [4];
  logic [7:0]  s1_col, s1_row;
  logic [8:0]  nwx, nwy;

  always_comb begin
    nwx = 9'd256 - {1'b0, head.wx};
    nwy = 9'd256 - {1'b0, head.wy};
  end

  // S2..S5
  logic        s2_vld, s3_vld, s4_vld;
  logic [24:0] s2_prod [3][4];
  logic [24:0] s3_sum  [3];
  logic [50:0] s4_scl  [3];
  logic [7:0]  s2_col, s2_row, s3_col, s3_row, s4_col, s4_row;
  logic [23:0] pix [4];
  logic [15:0] q   [3];

  always_comb begin
    pix[0] = rdata[{s1_y0p, s1_x0p}];
    pix[1] = rdata[{s1_y0p, s1_x1p}];
    pix[2] = rdata[{s1_y1p, s1_x0p}];
    pix[3] = rdata[{s1_y1p, s1_x1p}];
    for (int c = 0; c < 3; c++) q[c] = s4_scl[c][NORM_SHIFT +: 16];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
      s2_vld <= 1'b0;
      s3_vld <= 1'b0;
      s4_vld <= 1'b0;
      done   <= 1'b0;
    end else begin
      s1_vld <= pop && (head.kind == KIND_CROP);
      s2_vld <= s1_vld;
      s3_vld <= s2_vld;
      s4_vld <= s3_vld;
      done   <= s4_vld;
    end
    s1_x0p <= head.x0[0];
    s1_x1p <= head.x1[0];
    s1_y0p <= head.y0[0];
    s1_y1p <= head.y1[0];
    s1_w[0] <= 17'(nwx) * 17'(nwy);
    s1_w[1] <= 17'(head.wx) * 17'(nwy);
    s1_w[2] <= 17'(nwx) * 17'(head.wy);
    s1_w[3] <= 17'(head.wx) * 17'(head.wy);
    s1_col <= head.col;
    s1_row <= head.row;
    for (int c = 0; c < 3; c++) begin
      for (int n = 0; n < 4; n++) begin
        s2_prod[c][n] <= 25'(pix[n][23 - 8*c -: 8]) * 25'(s1_w[n]);
      end
      s3_sum[c] <= s2_prod[c][0] + s2_prod[c][1] + s2_prod[c][2] + s2_prod[c][3]
                   + ROUND_BIAS;
      s4_scl[c] <= 51'(s3_sum[c]) * 51'(NORM_RECIP);
    end
    s2_col <= s1_col;
    s2_row <= s1_row;
    s3_col <= s2_col;
    s3_row <= s2_row;
    s4_col <= s3_col;
    s4_row <= s3_row;
    result.red_out   <= $signed(q[0]) - ZERO_POINT;
    result.green_out <= $signed(q[1]) - ZERO_POINT;
    result.blue_out  <= $signed(q[2]) - ZERO_POINT;
    result.out_col   <= s4_col;
    result.out_row   <= s4_row;
  end

endmodule

// File: design/bilinear_roi_crop_resize.sv
// ----------------------------------------------------------------------------
// bilinear_roi_crop_resize
// Square-box bilinear crop and resize out of a stored RGB frame.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats go in on start/item and are taken at an edge where start is
//   high and busy is low. A store beat (kind 0) writes one source pixel; a
//   crop beat (kind 1) asks for one output pixel of the crop.
//   Each crop beat yields one result beat on result, flagged by done for a
//   single cycle; store beats yield nothing. Results come out in request
//   order.
//   Registers are written through wr_en/wr_index/wr_data, one per edge. The
//   user must write them only while no beat is in flight; the block itself
//   does not enforce this. Throughput: one beat per cycle while busy is low,
//   stores and requests mixed freely. The coordinate divider (26 quotient
//   bits at default parameters) dominates the pipeline; the parity-banked
//   frame store serves all four taps in the same cycle.
//   The receiver has no stall; busy only rises if the job queue fills.
//   Reset restores the register defaults and empties every pipeline; the
//   frame store is not cleared and must be loaded before it is sampled.
// ----------------------------------------------------------------------------
`include "bilinear_roi_crop_resize_macros.svh"

module bilinear_roi_crop_resize #(
  parameter int SRC_MAX_WIDTH = 256,
  parameter int SRC_MAX_HEIGHT = 256,
  parameter int CROP_MAX_SIDE = 256
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  brcr_pkg::in_item_t  item,
  output logic                busy,
  output logic                done,
  output brcr_pkg::out_item_t result,
  input  logic                wr_en,
  input  logic [2:0]          wr_index,
  input  logic [15:0]         wr_data
);
  import brcr_pkg::*;

  cfg_t cfg;

  // register file
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (wr_en) begin
      unique case (reg_index_e'(wr_index))
        REG_SOURCE_WIDTH:  cfg.source_width  <= wr_data[8:0];
        REG_SOURCE_HEIGHT: cfg.source_height <= wr_data[8:0];
        REG_CROP_WIDTH:    cfg.crop_width    <= wr_data[8:0];
        REG_CROP_HEIGHT:   cfg.crop_height   <= wr_data[8:0];
        REG_BOX_CENTER_X:  cfg.box_center_x  <= wr_data;
        REG_BOX_CENTER_Y:  cfg.box_center_y  <= wr_data;
        REG_BOX_WIDTH:     cfg.box_width     <= wr_data;
        REG_BOX_HEIGHT:    cfg.box_height    <= wr_data;
      endcase
    end
  end

  logic full, push, pop, empty;
  job_t job, head;

  // front: accept, classify, map coordinates
  brcr_front #(
    .SRC_MAX_WIDTH(SRC_MAX_WIDTH),
    .SRC_MAX_HEIGHT(SRC_MAX_HEIGHT),
    .CROP_MAX_SIDE(CROP_MAX_SIDE)
  ) u_front (
    .clk(clk), .rst(rst), .cfg(cfg), .start(start), .item(item),
    .busy(busy), .full(full), .push(push), .job(job)
  );

  // decoupling queue
  brcr_queue u_queue (
    .clk(clk), .rst(rst), .push(push), .job_in(job), .full(full),
    .pop(pop), .empty(empty), .head(head)
  );

  // back: frame store, blend, output
  brcr_back #(
    .SRC_MAX_WIDTH(SRC_MAX_WIDTH),
    .SRC_MAX_HEIGHT(SRC_MAX_HEIGHT)
  ) u_back (
    .clk(clk), .rst(rst), .empty(empty), .head(head), .pop(pop),
    .done(done), .result(result)
  );

  // all three channels inside [-1,1]
  logic out_ok;
  assign out_ok = (result.red_out >= -ZERO_POINT) && (result.red_out <= ZERO_POINT) &&
                  (result.green_out >= -ZERO_POINT) && (result.green_out <= ZERO_POINT) &&
                  (result.blue_out >= -ZERO_POINT) && (result.blue_out <= ZERO_POINT);

  `BRCR_ASSERT_IMPL(a_out_range, done, out_ok, "result outside [-1,1]")

endmodule

// File: sim/tb.sv
// ----------------------------------------------------------------------------
// tb - bilinear_roi_crop_resize testbench
// Loads source pixels, requests crop pixels under several register settings
// and compares every result beat with an in-bench bilinear predictor.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import brcr_pkg::*;

  localparam int LATENCY = 39;
  localparam int DRAIN_CYCLES = 80;
  localparam int WATCHDOG_LIMIT = 20000;

  // expected crop pixels, oldest first
  class crop_scoreboard;
    out_item_t pending[$];
    int errors;
    logic [23:0] frame[int];
    cfg_t cfg;

    function new();
      errors = 0;
      cfg = CFG_RESET;
    endfunction

    function void set_reg(reg_index_e idx, logic [15:0] val);
      case (idx)
        REG_SOURCE_WIDTH:  cfg.source_width = val[8:0];
        REG_SOURCE_HEIGHT: cfg.source_height = val[8:0];
        REG_CROP_WIDTH:    cfg.crop_width = val[8:0];
        REG_CROP_HEIGHT:   cfg.crop_height = val[8:0];
        REG_BOX_CENTER_X:  cfg.box_center_x = val;
        REG_BOX_CENTER_Y:  cfg.box_center_y = val;
        REG_BOX_WIDTH:     cfg.box_width = val;
        REG_BOX_HEIGHT:    cfg.box_height = val;
        default: ;
      endcase
    endfunction

    function longint fdiv(longint a, longint b);
      longint q;
      q = a / b;
      if ((a % b) != 0 && a < 0) q--;
      return q;
    endfunction

    function longint eff(logic [8:0] r);
      if (r == 0) return 1;
      return (r > 256) ? 256 : r;
    endfunction

    // source index pair and Q8 weight for one axis
    function void axis(longint center, longint side, longint c, longint crop,
                       longint size, output longint i0, output longint i1,
                       output longint w);
      longint s, a;
      s = center + fdiv(side * (2 * c + 1 - crop), 2 * crop);
      a = fdiv(s, 256);
      w = s - a * 256;
      i0 = (a < 0) ? 0 : ((a > size - 1) ? size - 1 : a);
      i1 = (a + 1 < 0) ? 0 : ((a + 1 > size - 1) ? size - 1 : a + 1);
    endfunction

    // source taps that a request for (col, row) reads
    function void locate(longint col, longint row, output longint x0,
                         output longint x1, output longint y0, output longint y1);
      longint m, side, wx, wy;
      m = (cfg.box_width > cfg.box_height) ? cfg.box_width : cfg.box_height;
      side = (m * 11 + 5) / 10;
      axis(cfg.box_center_x, side, col, eff(cfg.crop_width),
           eff(cfg.source_width), x0, x1, wx);
      axis(cfg.box_center_y, side, row, eff(cfg.crop_height),
           eff(cfg.source_height), y0, y1, wy);
    endfunction

    function void note_beat(in_item_t it);
      longint m, side, x0, x1, wx, y0, y1, wy, v, wt[4];
      logic [23:0] px[4];
      out_item_t o;
      if (it.kind == KIND_STORE) begin
        frame[{it.src_row, it.src_col}] = {it.red_in, it.green_in, it.blue_in};
        return;
      end
      m = (cfg.box_width > cfg.box_height) ? cfg.box_width : cfg.box_height;
      side = (m * 11 + 5) / 10;
      axis(cfg.box_center_x, side, it.crop_col, eff(cfg.crop_width),
           eff(cfg.source_width), x0, x1, wx);
      axis(cfg.box_center_y, side, it.crop_row, eff(cfg.crop_height),
           eff(cfg.source_height), y0, y1, wy);
      wt[0] = (256 - wx) * (256 - wy);
      wt[1] = wx * (256 - wy);
      wt[2] = (256 - wx) * wy;
      wt[3] = wx * wy;
      px[0] = frame.exists(y0 * 256 + x0) ? frame[y0 * 256 + x0] : 24'd0;
      px[1] = frame.exists(y0 * 256 + x1) ? frame[y0 * 256 + x1] : 24'd0;
      px[2] = frame.exists(y1 * 256 + x0) ? frame[y1 * 256 + x0] : 24'd0;
      px[3] = frame.exists(y1 * 256 + x1) ? frame[y1 * 256 + x1] : 24'd0;
      for (int ch = 0; ch < 3; ch++) begin
        v = 0;
        for (int k = 0; k < 4; k++) v += longint'(px[k][16 - 8 * ch +: 8]) * wt[k];
        v = (v + 255) / 510 - 16384;
        if (ch == 0) o.red_out = v[15:0];
        else if (ch == 1) o.green_out = v[15:0];
        else o.blue_out = v[15:0];
      end
      o.out_col = it.crop_col;
      o.out_row = it.crop_row;
      pending.push_back(o);
    endfunction

    function void check_beat(out_item_t got);
      out_item_t exp_o;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %p", $time, got);
        errors++;
        return;
      end
      exp_o = pending.pop_front();
      if (got !== exp_o) begin
        $display("%0t: mismatch expected %p actual %p", $time, exp_o, got);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  in_item_t item = '0;
  logic busy, done;
  out_item_t result;
  logic wr_en = 1'b0;
  logic [2:0] wr_index = '0;
  logic [15:0] wr_data = '0;

  crop_scoreboard sb = new();
  int send_idle_pct = 0;
  int stall_cycles = 0;
  int sent = 0;
  bit timed_out = 0;
  logic written[int];   // pixels already stored, so requests never read holes

  always #10 clk = ~clk;

  bilinear_roi_crop_resize u_top (
    .clk(clk), .rst(rst), .start(start), .item(item), .busy(busy),
    .done(done), .result(result), .wr_en(wr_en), .wr_index(wr_index),
    .wr_data(wr_data)
  );

  // check and accept at the same edge the DUT presents them
  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) sb.note_beat(item);
      if (done) sb.check_beat(result);
      if ((start && !busy) || done) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles > WATCHDOG_LIMIT && !timed_out) begin
        timed_out = 1;
        $display("** bilinear_roi_crop_resize: FAILED **");
        $finish;
      end
    end
  end

  // one input beat; random idle cycles in front. start stays high after the
  // accepting edge so the next beat can follow with no gap; drain lowers it.
  task automatic send_beat(in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    item <= it;
    do @(posedge clk); while (busy);
    sent++;
    if (it.kind == KIND_STORE) written[{it.src_row, it.src_col}] = 1;
  endtask

  task automatic store_px(int col, int row, logic [23:0] rgb);
    in_item_t it;
    it = '0;
    it.kind = KIND_STORE;
    it.src_col = 8'(col);
    it.src_row = 8'(row);
    {it.red_in, it.green_in, it.blue_in} = rgb;
    it.crop_col = 8'($urandom);
    it.crop_row = 8'($urandom);
    send_beat(it);
  endtask

  // store any tap the request would read that has no pixel yet
  task automatic fill_taps(int col, int row);
    longint x0, x1, y0, y1;
    longint xs[2];
    longint ys[2];
    sb.locate(col, row, x0, x1, y0, y1);
    xs[0] = x0;
    xs[1] = x1;
    ys[0] = y0;
    ys[1] = y1;
    for (int j = 0; j < 2; j++)
      for (int i = 0; i < 2; i++)
        if (!written.exists(int'(ys[j] * 256 + xs[i])))
          store_px(int'(xs[i]), int'(ys[j]), 24'($urandom));
  endtask

  task automatic request_px(int col, int row);
    in_item_t it;
    fill_taps(col, row);
    it = '0;
    it.kind = KIND_CROP;
    it.src_col = 8'($urandom);
    it.src_row = 8'($urandom);
    {it.red_in, it.green_in, it.blue_in} = 24'($urandom);
    it.crop_col = 8'(col);
    it.crop_row = 8'(row);
    send_beat(it);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  task automatic write_reg(reg_index_e idx, logic [15:0] val);
    @(posedge clk);
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= val;
    @(posedge clk);
    wr_en <= 1'b0;
    sb.set_reg(idx, val);
  endtask

  task automatic setup(int sw, int sh, int cw, int chh, int cx, int cy, int bw, int bh);
    drain();
    write_reg(REG_SOURCE_WIDTH, 16'(sw));
    write_reg(REG_SOURCE_HEIGHT, 16'(sh));
    write_reg(REG_CROP_WIDTH, 16'(cw));
    write_reg(REG_CROP_HEIGHT, 16'(chh));
    write_reg(REG_BOX_CENTER_X, 16'(cx));
    write_reg(REG_BOX_CENTER_Y, 16'(cy));
    write_reg(REG_BOX_WIDTH, 16'(bw));
    write_reg(REG_BOX_HEIGHT, 16'(bh));
  endtask

  // mostly requests with a few stores to fresh or old pixels
  task automatic random_phase(int n);
    int stop;
    stop = sent + n;
    while (sent < stop) begin
      if ($urandom_range(99) < 25)
        store_px($urandom_range(255), $urandom_range(255), 24'($urandom));
      else if ($urandom_range(9) == 0)
        request_px($urandom_range(255), $urandom_range(255));
      else
        request_px($urandom_range(int'(sb.eff(sb.cfg.crop_width)) - 1),
                   $urandom_range(int'(sb.eff(sb.cfg.crop_height)) - 1));
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed: extremes of the fields and the special cases
    store_px(0, 0, 24'h000000);
    store_px(255, 255, 24'hffffff);
    store_px(255, 0, 24'hff00ff);
    store_px(0, 255, 24'h00ff00);
    request_px(0, 0);
    request_px(111, 111);
    request_px(255, 255);   // beyond crop size
    request_px(0, 255);
    setup(0, 0, 0, 0, 0, 0, 0, 0);            // zero sizes act as one
    request_px(0, 0);
    request_px(255, 0);
    setup(511, 511, 511, 511, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
    request_px(0, 0);
    request_px(255, 255);
    request_px(128, 3);
    setup(256, 256, 1, 1, 100, 200, 300, 50);
    request_px(0, 0);
    setup(64, 32, 256, 256, 16'h1000, 16'h0800, 16'h2000, 16'h4000);
    request_px(0, 0);
    request_px(255, 255);
    store_px(63, 31, 24'h123456);
    request_px(17, 200);

    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 18 : ((ph == 1) ? 71 : 0);
      for (int k = 0; k < 5; k++) begin
        setup($urandom_range(511), $urandom_range(511), $urandom_range(511),
              $urandom_range(511), $urandom, $urandom, $urandom, $urandom);
        random_phase(66);
      end
    end
    setup(256, 256, 112, 112, 32768, 32768, 16384, 16384);
    if (sent < 1050) random_phase(1050 - sent);

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("** bilinear_roi_crop_resize: PASSED **");
    else
      $display("** bilinear_roi_crop_resize: FAILED **");
    $finish;
  end
endmodule
